@@ src/lfps_pkg.sv @@
`default_nettype none
package lfps_pkg;

    typedef enum logic [9:0] {
        PH_HUNT  = 10'b00_0000_0001,
        PH_HDR2  = 10'b00_0000_0010,
        PH_CTRL  = 10'b00_0000_0100,
        PH_CMD   = 10'b00_0000_1000,
        PH_LENHI = 10'b00_0001_0000,
        PH_LENLO = 10'b00_0010_0000,
        PH_DATA  = 10'b00_0100_0000,
        PH_CSUM  = 10'b00_1000_0000,
        PH_TRL1  = 10'b01_0000_0000,
        PH_TRL2  = 10'b10_0000_0000
    } t_phase;

    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_CSUM_BAD = 2'd1;
    localparam logic [1:0] ST_TRL_BAD  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN        = 3'd4;

    localparam logic [7:0]  RST_HEADER_FIRST   = 8'h53;
    localparam logic [7:0]  RST_HEADER_SECOND  = 8'h59;
    localparam logic [7:0]  RST_TRAILER_FIRST  = 8'h54;
    localparam logic [7:0]  RST_TRAILER_SECOND = 8'h43;
    localparam logic [15:0] RST_MAX_LEN        = 16'd1024;

    typedef struct packed {
        logic [7:0]  header_first;
        logic [7:0]  header_second;
        logic [7:0]  trailer_first;
        logic [7:0]  trailer_second;
        logic [15:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_ctrl;
        logic [7:0]  frame_cmd;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [15:0] frame_length;
        logic [1:0]  status;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

@@ src/lfps_cfg.sv @@
`default_nettype none
module lfps_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_we,
    input  wire logic [lfps_pkg::CFG_IDX_W-1:0]     i_index,
    input  wire logic [lfps_pkg::CFG_DATA_W-1:0]    i_data,
    output lfps_pkg::t_cfg                          o_cfg
);

    lfps_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first   <= lfps_pkg::RST_HEADER_FIRST;
            r_cfg.header_second  <= lfps_pkg::RST_HEADER_SECOND;
            r_cfg.trailer_first  <= lfps_pkg::RST_TRAILER_FIRST;
            r_cfg.trailer_second <= lfps_pkg::RST_TRAILER_SECOND;
            r_cfg.max_len        <= lfps_pkg::RST_MAX_LEN;
        end else if (i_we) begin
            case (i_index)
                lfps_pkg::REG_HEADER_FIRST:   r_cfg.header_first   <= i_data[7:0];
                lfps_pkg::REG_HEADER_SECOND:  r_cfg.header_second  <= i_data[7:0];
                lfps_pkg::REG_TRAILER_FIRST:  r_cfg.trailer_first  <= i_data[7:0];
                lfps_pkg::REG_TRAILER_SECOND: r_cfg.trailer_second <= i_data[7:0];
                lfps_pkg::REG_MAX_LEN:        r_cfg.max_len        <= i_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

@@ src/lfps_parse.sv @@
`default_nettype none
module lfps_parse (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire lfps_pkg::t_cfg i_cfg,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_byte,
    output logic             o_res_valid,
    output lfps_pkg::t_result o_res
);

    lfps_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [15:0] r_seen, n_seen;
    logic [7:0]  r_sum, n_sum;
    logic        r_csum_ok, n_csum_ok;
    logic        r_trl1_ok, n_trl1_ok;

    logic        res_hit;
    logic        res_kind;
    logic [7:0]  res_byte;
    logic [15:0] res_index;
    logic [1:0]  res_status;
    logic [7:0]  sum_plus;
    logic [15:0] seen_plus;

    assign sum_plus  = r_sum + i_byte;
    assign seen_plus = r_seen + 16'd1;

    always_comb begin
        n_phase    = r_phase;
        n_ctrl     = r_ctrl;
        n_cmd      = r_cmd;
        n_len      = r_len;
        n_seen     = r_seen;
        n_sum      = r_sum;
        n_csum_ok  = r_csum_ok;
        n_trl1_ok  = r_trl1_ok;
        res_hit    = 1'b0;
        res_kind   = lfps_pkg::KIND_PAYLOAD;
        res_byte   = 8'd0;
        res_index  = 16'd0;
        res_status = lfps_pkg::ST_GOOD;
        case (r_phase)
            lfps_pkg::PH_HDR2: begin
                // The second header check wins, so equal header bytes still sync.
                if (i_byte == i_cfg.header_second) begin
                    n_sum   = sum_plus;
                    n_phase = lfps_pkg::PH_CTRL;
                end else if (i_byte == i_cfg.header_first) begin
                    n_phase = lfps_pkg::PH_HDR2;
                    n_sum   = i_byte;
                    n_ctrl  = 8'd0;
                    n_cmd   = 8'd0;
                end else begin
                    n_phase = lfps_pkg::PH_HUNT;
                    n_sum   = 8'd0;
                end
            end
            lfps_pkg::PH_CTRL: begin
                n_ctrl  = i_byte;
                n_sum   = sum_plus;
                n_phase = lfps_pkg::PH_CMD;
            end
            lfps_pkg::PH_CMD: begin
                n_cmd   = i_byte;
                n_sum   = sum_plus;
                n_phase = lfps_pkg::PH_LENHI;
            end
            lfps_pkg::PH_LENHI: begin
                n_len   = {i_byte, 8'd0};
                n_sum   = sum_plus;
                n_phase = lfps_pkg::PH_LENLO;
            end
            lfps_pkg::PH_LENLO: begin
                n_len  = {r_len[15:8], i_byte};
                n_sum  = sum_plus;
                n_seen = 16'd0;
                if (n_len > i_cfg.max_len) begin
                    res_hit    = 1'b1;
                    res_kind   = lfps_pkg::KIND_END;
                    res_status = lfps_pkg::ST_TOO_LONG;
                    n_phase    = lfps_pkg::PH_HUNT;
                    n_sum      = 8'd0;
                end else if (n_len == 16'd0) begin
                    n_phase = lfps_pkg::PH_CSUM;
                end else begin
                    n_phase = lfps_pkg::PH_DATA;
                end
            end
            lfps_pkg::PH_DATA: begin
                res_hit   = 1'b1;
                res_byte  = i_byte;
                res_index = r_seen;
                n_sum     = sum_plus;
                n_seen    = seen_plus;
                if (seen_plus >= r_len) begin
                    n_phase = lfps_pkg::PH_CSUM;
                end
            end
            lfps_pkg::PH_CSUM: begin
                n_csum_ok = (i_byte == r_sum);
                n_phase   = lfps_pkg::PH_TRL1;
            end
            lfps_pkg::PH_TRL1: begin
                n_trl1_ok = (i_byte == i_cfg.trailer_first);
                n_phase   = lfps_pkg::PH_TRL2;
            end
            lfps_pkg::PH_TRL2: begin
                res_hit  = 1'b1;
                res_kind = lfps_pkg::KIND_END;
                if (!r_csum_ok) begin
                    res_status = lfps_pkg::ST_CSUM_BAD;
                end else if (!r_trl1_ok || i_byte != i_cfg.trailer_second) begin
                    res_status = lfps_pkg::ST_TRL_BAD;
                end else begin
                    res_status = lfps_pkg::ST_GOOD;
                end
                n_phase = lfps_pkg::PH_HUNT;
                n_sum   = 8'd0;
            end
            default: begin
                // Hunting, and any code that does not name a phase.
                if (i_byte == i_cfg.header_first) begin
                    n_phase = lfps_pkg::PH_HDR2;
                    n_sum   = i_byte;
                    n_ctrl  = 8'd0;
                    n_cmd   = 8'd0;
                end else begin
                    n_phase = lfps_pkg::PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lfps_pkg::PH_HUNT;
            r_ctrl    <= 8'd0;
            r_cmd     <= 8'd0;
            r_len     <= 16'd0;
            r_seen    <= 16'd0;
            r_sum     <= 8'd0;
            r_csum_ok <= 1'b0;
            r_trl1_ok <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_ctrl    <= n_ctrl;
            r_cmd     <= n_cmd;
            r_len     <= n_len;
            r_seen    <= n_seen;
            r_sum     <= n_sum;
            r_csum_ok <= n_csum_ok;
            r_trl1_ok <= n_trl1_ok;
        end
    end

    assign o_res_valid = i_accept & res_hit;
    assign o_res       = '{kind: res_kind, frame_ctrl: r_ctrl, frame_cmd: r_cmd,
                           payload_byte: res_byte, payload_index: res_index,
                           frame_length: n_len, status: res_status, last: res_kind};

`ifndef SYNTHESIS
    a_end_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last |=> r_phase == lfps_pkg::PH_HUNT)
        else $error("frame end did not return the parser to hunting");
    a_data_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == lfps_pkg::PH_DATA |-> r_seen < r_len)
        else $error("payload count ran past the declared length");
    a_payload_only_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last |-> r_phase == lfps_pkg::PH_DATA)
        else $error("payload beat produced outside the payload phase");
`endif

endmodule
`default_nettype wire

@@ src/lfps_outreg.sv @@
`default_nettype none
module lfps_outreg (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire lfps_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    input  wire logic         i_ready,
    output lfps_pkg::t_result o_data
);

    logic              r_out_valid;
    logic              r_skid_valid;
    lfps_pkg::t_result r_out;
    lfps_pkg::t_result r_skid;
    logic              out_free;

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid | i_valid;
            r_skid_valid <= 1'b0;
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_valid) begin
            r_skid <= i_data;
        end
    end

    // The skid entry only fills while the output is stalled, so one spare beat is enough.
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while the output register is empty");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !r_skid_valid)
        else $error("result arrived while both output entries were full");
    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready && i_valid |=> r_skid_valid)
        else $error("result during a stall was not held in the skid entry");
`endif

endmodule
`default_nettype wire

@@ src/length_frame_parser_sum8.sv @@
`default_nettype none
// Byte-serial parser for length-prefixed frames with an 8-bit sum checksum. One received
// byte is taken per beat on the input channel, and a new byte can be accepted every clock
// cycle while o_ready is high: each byte is decoded by a single state machine step built
// from one 8-bit adder, a 16-bit payload counter and a few compares, and its result goes
// straight into an output register. A two-entry output stage (output register plus skid
// entry) lets the input keep flowing while a result waits, so input ready drops only after
// two results are left waiting. Each payload byte yields one result beat; the second
// trailer byte, or a length above the limit, yields one frame end beat with the verdict.
// Other bytes yield nothing. The result of a byte is offered on the output in the cycle
// after it is accepted, unless earlier results are still waiting there. Registers are to
// be written through the configuration port in cycles where no byte is accepted, which
// the block does not enforce; a new value applies from the next byte on, also mid-frame.
module length_frame_parser_sum8 (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lfps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lfps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [7:0]                      i_rx_byte,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_kind,
    output logic [7:0]                           o_frame_ctrl,
    output logic [7:0]                           o_frame_cmd,
    output logic [7:0]                           o_payload_byte,
    output logic [15:0]                          o_payload_index,
    output logic [15:0]                          o_frame_length,
    output logic [1:0]                           o_status,
    output logic                                 o_last
);

    lfps_pkg::t_cfg    cfg;
    lfps_pkg::t_result res;
    lfps_pkg::t_result out_res;
    logic              res_valid;
    logic              accept;

    assign accept = i_valid & o_ready;

    lfps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lfps_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_byte      (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lfps_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_res)
    );

    assign o_kind          = out_res.kind;
    assign o_frame_ctrl    = out_res.frame_ctrl;
    assign o_frame_cmd     = out_res.frame_cmd;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_payload_index = out_res.payload_index;
    assign o_frame_length  = out_res.frame_length;
    assign o_status        = out_res.status;
    assign o_last          = out_res.last;

endmodule
`default_nettype wire

@@ dv/length_frame_parser_sum8_tb.sv @@
module length_frame_parser_sum8_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES  = 1450;
    localparam int SETTLE_CYCLES = 3;
    localparam int TAIL_CYCLES   = 8;
    localparam int STALL_LIMIT   = 4000;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [lfps_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [lfps_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                            i_valid     = 1'b0;
    logic                            o_ready;
    logic [7:0]                      i_rx_byte   = '0;
    logic                            o_valid;
    logic                            i_ready     = 1'b0;
    logic                            o_kind;
    logic [7:0]                      o_frame_ctrl;
    logic [7:0]                      o_frame_cmd;
    logic [7:0]                      o_payload_byte;
    logic [15:0]                     o_payload_index;
    logic [15:0]                     o_frame_length;
    logic [1:0]                      o_status;
    logic                            o_last;

    length_frame_parser_sum8 dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef struct {
        bit                             is_reg;
        logic [lfps_pkg::CFG_IDX_W-1:0] idx;
        logic [15:0]                    val;
        bit                             typed;
        lfps_pkg::t_result              want;
    } t_row;

    typedef struct {
        logic [lfps_pkg::CFG_IDX_W-1:0] idx;
        logic [15:0]                    val;
    } t_reg_write;

    // Register copies as the parser sees them.
    logic [7:0]  sync1     = lfps_pkg::RST_HEADER_FIRST;
    logic [7:0]  sync2     = lfps_pkg::RST_HEADER_SECOND;
    logic [7:0]  tail1     = lfps_pkg::RST_TRAILER_FIRST;
    logic [7:0]  tail2     = lfps_pkg::RST_TRAILER_SECOND;
    logic [15:0] len_limit = lfps_pkg::RST_MAX_LEN;

    // Parser state of the predictor.
    lfps_pkg::t_phase ph   = lfps_pkg::PH_HUNT;
    logic [7:0]  cur_ctrl  = '0;
    logic [7:0]  cur_cmd   = '0;
    logic [15:0] cur_len   = '0;
    logic [15:0] pay_count = '0;
    logic [7:0]  sum8      = '0;
    bit          sum_ok    = 1'b0;
    bit          tail1_ok  = 1'b0;

    lfps_pkg::t_result pending_beats[$];
    bit                typed_on = 1'b0;
    lfps_pkg::t_result typed_want = '0;

    int errors        = 0;
    int quiet_cycles  = 0;
    int bytes_sent    = 0;
    int settings_used = 0;
    int payload_beats = 0;
    int verdicts[4]   = '{0, 0, 0, 0};
    int calm_left     = 0;

    task automatic note_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    function automatic void start_hunt_hit(input logic [7:0] b);
        ph       = lfps_pkg::PH_HDR2;
        sum8     = b;
        cur_ctrl = '0;
        cur_cmd  = '0;
    endfunction

    // Advances the parser by one received byte; returns 1 when the byte yields a beat.
    function automatic bit parse_byte(input logic [7:0] b, output lfps_pkg::t_result beat);
        bit made;
        made = 1'b0;
        beat = '0;
        case (ph)
            lfps_pkg::PH_HDR2: begin
                if (b == sync2) begin
                    sum8 = sum8 + b;
                    ph   = lfps_pkg::PH_CTRL;
                end else if (b == sync1) begin
                    start_hunt_hit(b);
                end else begin
                    ph   = lfps_pkg::PH_HUNT;
                    sum8 = '0;
                end
            end
            lfps_pkg::PH_CTRL: begin
                cur_ctrl = b;
                sum8     = sum8 + b;
                ph       = lfps_pkg::PH_CMD;
            end
            lfps_pkg::PH_CMD: begin
                cur_cmd = b;
                sum8    = sum8 + b;
                ph      = lfps_pkg::PH_LENHI;
            end
            lfps_pkg::PH_LENHI: begin
                cur_len = {b, 8'h00};
                sum8    = sum8 + b;
                ph      = lfps_pkg::PH_LENLO;
            end
            lfps_pkg::PH_LENLO: begin
                cur_len[7:0] = b;
                sum8         = sum8 + b;
                pay_count    = '0;
                if (cur_len > len_limit) begin
                    made        = 1'b1;
                    beat.kind   = lfps_pkg::KIND_END;
                    beat.status = lfps_pkg::ST_TOO_LONG;
                    ph          = lfps_pkg::PH_HUNT;
                    sum8        = '0;
                end else if (cur_len == 0) begin
                    ph = lfps_pkg::PH_CSUM;
                end else begin
                    ph = lfps_pkg::PH_DATA;
                end
            end
            lfps_pkg::PH_DATA: begin
                made               = 1'b1;
                beat.kind          = lfps_pkg::KIND_PAYLOAD;
                beat.payload_byte  = b;
                beat.payload_index = pay_count;
                sum8               = sum8 + b;
                pay_count          = pay_count + 16'd1;
                if (pay_count >= cur_len)
                    ph = lfps_pkg::PH_CSUM;
            end
            lfps_pkg::PH_CSUM: begin
                sum_ok = (b == sum8);
                ph     = lfps_pkg::PH_TRL1;
            end
            lfps_pkg::PH_TRL1: begin
                tail1_ok = (b == tail1);
                ph       = lfps_pkg::PH_TRL2;
            end
            lfps_pkg::PH_TRL2: begin
                made      = 1'b1;
                beat.kind = lfps_pkg::KIND_END;
                // A bad checksum outranks a bad trailer.
                if (!sum_ok)
                    beat.status = lfps_pkg::ST_CSUM_BAD;
                else if (!tail1_ok || b != tail2)
                    beat.status = lfps_pkg::ST_TRL_BAD;
                else
                    beat.status = lfps_pkg::ST_GOOD;
                ph   = lfps_pkg::PH_HUNT;
                sum8 = '0;
            end
            default: begin
                if (b == sync1)
                    start_hunt_hit(b);
                else
                    ph = lfps_pkg::PH_HUNT;
            end
        endcase
        beat.frame_ctrl   = cur_ctrl;
        beat.frame_cmd    = cur_cmd;
        beat.frame_length = cur_len;
        beat.last         = beat.kind;
        return made;
    endfunction

    task automatic check_beat(input lfps_pkg::t_result got, input lfps_pkg::t_result want);
        if (got.kind !== want.kind)
            note_mismatch("kind", 16'(got.kind), 16'(want.kind));
        if (got.frame_ctrl !== want.frame_ctrl)
            note_mismatch("frame_ctrl", 16'(got.frame_ctrl), 16'(want.frame_ctrl));
        if (got.frame_cmd !== want.frame_cmd)
            note_mismatch("frame_cmd", 16'(got.frame_cmd), 16'(want.frame_cmd));
        if (got.payload_byte !== want.payload_byte)
            note_mismatch("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
        if (got.payload_index !== want.payload_index)
            note_mismatch("payload_index", got.payload_index, want.payload_index);
        if (got.frame_length !== want.frame_length)
            note_mismatch("frame_length", got.frame_length, want.frame_length);
        if (got.status !== want.status)
            note_mismatch("status", 16'(got.status), 16'(want.status));
        if (got.last !== want.last)
            note_mismatch("last", 16'(got.last), 16'(want.last));
    endtask

    always @(posedge i_clk) begin : port_watch
        lfps_pkg::t_result got;
        lfps_pkg::t_result pred;
        bit                made;
        bit                moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_valid && o_ready) begin
                moved = 1'b1;
                made  = parse_byte(i_rx_byte, pred);
                if (typed_on)
                    pending_beats.push_back(typed_want);
                else if (made)
                    pending_beats.push_back(pred);
            end
            if (o_valid && i_ready) begin
                moved = 1'b1;
                got = '{kind: o_kind, frame_ctrl: o_frame_ctrl, frame_cmd: o_frame_cmd,
                        payload_byte: o_payload_byte, payload_index: o_payload_index,
                        frame_length: o_frame_length, status: o_status, last: o_last};
                if (pending_beats.size() == 0) begin
                    note_mismatch("result beat with nothing pending", 16'(o_kind), 16'd0);
                end else begin
                    check_beat(got, pending_beats.pop_front());
                    if (got.kind == lfps_pkg::KIND_END)
                        verdicts[got.status]++;
                    else
                        payload_beats++;
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("length_frame_parser_sum8_tb NOT OK");
        $finish;
    end

    // Result side: mostly short stalls, a few long ones, and stretches of steady ready.
    initial begin : sink_pace
        int run;
        int r;
        run = 0;
        forever begin
            @(negedge i_clk);
            if (run > 0) begin
                run--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    i_ready <= 1'b1;
                    run = $urandom_range(30, 120);
                end else if (r < 65) begin
                    i_ready <= 1'b1;
                    run = $urandom_range(0, 4);
                end else if (r < 93) begin
                    i_ready <= 1'b0;
                    run = $urandom_range(0, 3);
                end else begin
                    i_ready <= 1'b0;
                    run = $urandom_range(10, 40);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm_left = $urandom_range(30, 100);
            return 0;
        end
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Registers change only once every pending result has come out and the
    // pipeline has had time to settle bytes that produce nothing.
    task automatic apply_regs(input t_reg_write w[$]);
        i_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        foreach (w[k]) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= w[k].idx;
            i_cfg_data  <= w[k].val;
            case (w[k].idx)
                lfps_pkg::REG_HEADER_FIRST:   sync1 = w[k].val[7:0];
                lfps_pkg::REG_HEADER_SECOND:  sync2 = w[k].val[7:0];
                lfps_pkg::REG_TRAILER_FIRST:  tail1 = w[k].val[7:0];
                lfps_pkg::REG_TRAILER_SECOND: tail2 = w[k].val[7:0];
                lfps_pkg::REG_MAX_LEN:        len_limit = w[k].val;
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] rand_octet();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_row rx(input logic [7:0] b);
        t_row r;
        r.is_reg = 1'b0;
        r.idx    = '0;
        r.val    = {8'h00, b};
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic t_row rx_end(input logic [7:0] b, input logic [7:0] ctrl,
                                    input logic [7:0] cmd, input logic [15:0] len,
                                    input logic [1:0] st);
        t_row r;
        r       = rx(b);
        r.typed = 1'b1;
        r.want  = '{kind: lfps_pkg::KIND_END, frame_ctrl: ctrl, frame_cmd: cmd,
                    payload_byte: 8'h00, payload_index: 16'h0000, frame_length: len,
                    status: st, last: 1'b1};
        return r;
    endfunction

    function automatic t_row reg_wr(input logic [lfps_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [15:0] val);
        t_row r;
        r        = rx(8'h00);
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    // One frame built from the current registers, now and then flawed or cut short.
    task automatic send_frame();
        logic [7:0]  seq[$];
        logic [7:0]  csum;
        logic [7:0]  b;
        logic [15:0] len;
        int          r;
        int          cap;
        int          flaw;
        bit          overlong;
        r   = $urandom_range(0, 99);
        cap = (len_limit < 12) ? int'(len_limit) : 12;
        if (r < 10 && len_limit < 16'hFFFF) begin
            if ($urandom_range(0, 3) == 0 || len_limit > 16'hFFF0)
                len = 16'hFFFF;
            else
                len = len_limit + 16'd1 + 16'($urandom_range(0, 2));
        end else if (r < 16 || len_limit == 0) begin
            len = '0;
        end else if (r < 19) begin
            len = 16'($urandom_range(1, (len_limit < 64) ? int'(len_limit) : 64));
        end else begin
            len = 16'($urandom_range(1, cap));
        end
        overlong = (len > len_limit);
        seq = {sync1, sync2, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               len[15:8], len[7:0]};
        if (!overlong) begin
            repeat (len) seq.push_back(8'($urandom_range(0, 255)));
            csum = '0;
            foreach (seq[k])
                csum = csum + seq[k];
            seq.push_back(csum);
            seq.push_back(tail1);
            seq.push_back(tail2);
        end
        flaw = $urandom_range(0, 99);
        if (!overlong && flaw >= 70 && flaw < 78)
            seq[seq.size()-3] = seq[seq.size()-3] ^ 8'($urandom_range(1, 255));
        else if (!overlong && flaw >= 78 && flaw < 85)
            seq[seq.size()-2] = seq[seq.size()-2] ^ 8'($urandom_range(1, 255));
        else if (!overlong && flaw >= 85 && flaw < 90)
            seq[seq.size()-1] = seq[seq.size()-1] ^ 8'($urandom_range(1, 255));
        else if (flaw >= 90 && flaw < 93)
            seq.insert(1, sync1);   // repeated first header byte restarts the frame
        else if (flaw >= 93 && flaw < 95) begin
            b = 8'($urandom_range(0, 255));
            while (b == sync1 || b == sync2)
                b = b + 8'd1;
            seq = {sync1, b};
        end else if (flaw >= 95)
            seq = seq[0:$urandom_range(0, seq.size()-2)];
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) push_byte(rand_octet());
        foreach (seq[k])
            push_byte(seq[k]);
    endtask

    initial begin : stimulus
        t_row       plan[$];
        t_reg_write regs[$];
        int         target;
        int         phase_end;
        int         phase_no;
        logic [7:0] h1;

        // Stray byte, repeated first header, broken sequence, then a length far over
        // the limit.
        plan.push_back(rx(8'h00));
        plan.push_back(rx(8'h53));
        plan.push_back(rx(8'h53));
        plan.push_back(rx(8'h11));
        plan.push_back(rx(8'h53));
        plan.push_back(rx(8'h59));
        plan.push_back(rx(8'h00));
        plan.push_back(rx(8'hFF));
        plan.push_back(rx(8'hFF));
        plan.push_back(rx_end(8'hFF, 8'h00, 8'hFF, 16'hFFFF, lfps_pkg::ST_TOO_LONG));
        // Empty payload with checksum and both trailer bytes wrong.
        plan.push_back(rx(8'h53));
        plan.push_back(rx(8'h59));
        plan.push_back(rx(8'hFF));
        plan.push_back(rx(8'h00));
        plan.push_back(rx(8'h00));
        plan.push_back(rx(8'h00));
        plan.push_back(rx(8'h00));
        plan.push_back(rx(8'h00));
        plan.push_back(rx_end(8'h00, 8'hFF, 8'h00, 16'h0000, lfps_pkg::ST_CSUM_BAD));
        // Limit dropped to zero in the middle of a frame.
        plan.push_back(rx(8'h53));
        plan.push_back(rx(8'h59));
        plan.push_back(rx(8'h01));
        plan.push_back(rx(8'h02));
        plan.push_back(rx(8'h00));
        plan.push_back(reg_wr(lfps_pkg::REG_MAX_LEN, 16'h0000));
        plan.push_back(rx_end(8'h01, 8'h01, 8'h02, 16'h0001, lfps_pkg::ST_TOO_LONG));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_reg) begin
                regs = {};
                regs.push_back('{plan[k].idx, plan[k].val});
                apply_regs(regs);
            end else begin
                typed_on   = plan[k].typed;
                typed_want = plan[k].want;
                push_byte(plan[k].val[7:0]);
            end
        end
        typed_on = 1'b0;

        target   = bytes_sent + RANDOM_BYTES;
        phase_no = 0;
        while (bytes_sent < target) begin
            regs = {};
            case (phase_no)
                0: begin
                    regs.push_back('{lfps_pkg::REG_HEADER_FIRST, 16'h0000});
                    regs.push_back('{lfps_pkg::REG_HEADER_SECOND, 16'h00FF});
                    regs.push_back('{lfps_pkg::REG_TRAILER_FIRST, 16'h00FF});
                    regs.push_back('{lfps_pkg::REG_TRAILER_SECOND, 16'h0000});
                    regs.push_back('{lfps_pkg::REG_MAX_LEN, 16'hFFFF});
                end
                1: begin
                    regs.push_back('{lfps_pkg::REG_HEADER_FIRST, 16'h00FF});
                    regs.push_back('{lfps_pkg::REG_HEADER_SECOND, 16'h00FF});
                    regs.push_back('{lfps_pkg::REG_TRAILER_FIRST, 16'h0000});
                    regs.push_back('{lfps_pkg::REG_TRAILER_SECOND, 16'h00FF});
                    regs.push_back('{lfps_pkg::REG_MAX_LEN, 16'($urandom_range(1, 20))});
                end
                default: begin
                    h1 = rand_octet();
                    regs.push_back('{lfps_pkg::REG_HEADER_FIRST, {8'h00, h1}});
                    // Equal header bytes now and then.
                    if ($urandom_range(0, 5) == 0)
                        regs.push_back('{lfps_pkg::REG_HEADER_SECOND, {8'h00, h1}});
                    else
                        regs.push_back('{lfps_pkg::REG_HEADER_SECOND,
                                         {8'h00, rand_octet()}});
                    regs.push_back('{lfps_pkg::REG_TRAILER_FIRST, {8'h00, rand_octet()}});
                    regs.push_back('{lfps_pkg::REG_TRAILER_SECOND, {8'h00, rand_octet()}});
                    case ($urandom_range(0, 5))
                        0:       regs.push_back('{lfps_pkg::REG_MAX_LEN, 16'h0000});
                        1:       regs.push_back('{lfps_pkg::REG_MAX_LEN, 16'hFFFF});
                        2:       regs.push_back('{lfps_pkg::REG_MAX_LEN,
                                                  lfps_pkg::RST_MAX_LEN});
                        default: regs.push_back('{lfps_pkg::REG_MAX_LEN,
                                                  16'($urandom_range(1, 20))});
                    endcase
                end
            endcase
            apply_regs(regs);
            phase_end = bytes_sent + $urandom_range(120, 200);
            while (bytes_sent < phase_end && bytes_sent < target)
                send_frame();
            phase_no++;
        end

        i_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Fed %0d bytes over %0d register settings; %0d payload beats matched.",
                 bytes_sent, settings_used, payload_beats);
        $display("Frame ends: %0d good, %0d bad checksum, %0d bad trailer, %0d too long.",
                 verdicts[lfps_pkg::ST_GOOD], verdicts[lfps_pkg::ST_CSUM_BAD],
                 verdicts[lfps_pkg::ST_TRL_BAD], verdicts[lfps_pkg::ST_TOO_LONG]);
        if (errors == 0)
            $display("length_frame_parser_sum8_tb OK");
        else
            $display("length_frame_parser_sum8_tb NOT OK");
        $finish;
    end

endmodule
